// File: hw/rtl/cctm_pkg.sv
package cctm_pkg;

  localparam int unsigned Entries = 4096;
  localparam int unsigned AddrW   = 12;
  localparam int unsigned DataW   = 16;
  localparam int unsigned CntW    = 13;
  localparam int unsigned StatW   = 3;
  localparam int unsigned KindW   = 2;

  localparam logic [DataW-1:0] EntryFree = 16'h0000;
  localparam logic [DataW-1:0] EntryEnd  = 16'hFFFF;

  localparam logic [AddrW-1:0] AllocBaseRst = 12'd17;

  localparam logic [StatW-1:0] StOk     = 3'd0;
  localparam logic [StatW-1:0] StFull   = 3'd1;
  localparam logic [StatW-1:0] StBad    = 3'd2;
  localparam logic [StatW-1:0] StBroken = 3'd3;
  localparam logic [StatW-1:0] StLoop   = 3'd4;

  localparam logic [KindW-1:0] KindAlloc  = 2'd0;
  localparam logic [KindW-1:0] KindFollow = 2'd1;
  localparam logic [KindW-1:0] KindFree   = 2'd2;
  localparam logic [KindW-1:0] KindLoad   = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [StatW-1:0] status;
    logic [DataW-1:0] cluster;
    logic [CntW-1:0]  count;
  } res_t;

  function automatic logic in_range(logic [DataW-1:0] c);
    return c[DataW-1:AddrW] == '0;
  endfunction

  function automatic logic valid_cluster(logic [DataW-1:0] c);
    return (c != EntryFree) && (c != EntryEnd) && in_range(c);
  endfunction

endpackage

// File: hw/rtl/cluster_chain_table_manager.sv
// cluster chain table manager: 4096-entry table of 16-bit chain links
// (0 free, 0xffff end of chain, else next cluster), held in one memory.
// input: a command is taken on a clock edge with start_i high and busy_o
//   low; kind_i picks allocate, follow link, free chain or load entry.
// output: every command gives one result, shown for exactly one cycle with
//   done_o high; the receiver cannot stall, so nothing is held back.
// config: alloc_base_we_i writes alloc_base_i (lowest cluster allocate may
//   return, or 1 if it is 0) at once; write it only while no command is in flight.
// steps from the transfer edge to done_o, which is registered from the result:
//   load entry and any command rejected up front: result at the transfer
//   follow link: table read, then result in state SFollow
//   allocate: scan in SScan over entries from the base up, then SEnd when linking
//   free chain: SWalk reads and frees each entry walked
// the memory port sets the pace: one table entry is read per cycle, and a full
// scan or walk covers up to 4096 entries.
// reset: alloc_base returns to 17 and the table is cleared to free by a
// pass over all 4096 entries, one entry a cycle, during which busy_o stays high.
module cluster_chain_table_manager (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [cctm_pkg::KindW-1:0]   kind_i,
  input  logic [cctm_pkg::DataW-1:0]   cluster_i,
  input  logic                         is_first_i,
  input  logic [cctm_pkg::DataW-1:0]   entry_value_i,
  input  logic                         alloc_base_we_i,
  input  logic [cctm_pkg::AddrW-1:0]   alloc_base_i,
  output logic                         done_o,
  output logic [cctm_pkg::StatW-1:0]   status_o,
  output logic [cctm_pkg::DataW-1:0]   cluster_out_o,
  output logic [cctm_pkg::CntW-1:0]    freed_count_o
);

  logic [cctm_pkg::AddrW-1:0] alloc_base_q;
  cctm_pkg::res_t             res;
  logic                       done_q;
  logic [cctm_pkg::StatW-1:0] status_q;
  logic [cctm_pkg::DataW-1:0] cluster_q;
  logic [cctm_pkg::CntW-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_base_q <= cctm_pkg::AllocBaseRst;
      done_q       <= 1'b0;
    end else begin
      if (alloc_base_we_i) begin
        alloc_base_q <= alloc_base_i;
      end
      done_q <= res.valid;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q  <= res.status;
      cluster_q <= res.cluster;
      count_q   <= res.count;
    end
  end

  cctm_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .kind_i        (kind_i),
    .cluster_i     (cluster_i),
    .is_first_i    (is_first_i),
    .entry_value_i (entry_value_i),
    .alloc_base_i  (alloc_base_q),
    .busy_o        (busy_o),
    .res_o         (res)
  );

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign cluster_out_o = cluster_q;
  assign freed_count_o = count_q;

endmodule

// File: hw/rtl/cctm_core.sv
module cctm_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cctm_pkg::KindW-1:0]   kind_i,
  input  logic [cctm_pkg::DataW-1:0]   cluster_i,
  input  logic                         is_first_i,
  input  logic [cctm_pkg::DataW-1:0]   entry_value_i,
  input  logic [cctm_pkg::AddrW-1:0]   alloc_base_i,
  output logic                         busy_o,
  output cctm_pkg::res_t               res_o
);

  localparam logic [2:0] SClear  = 3'd0;
  localparam logic [2:0] SIdle   = 3'd1;
  localparam logic [2:0] SScan   = 3'd2;
  localparam logic [2:0] SEnd    = 3'd3;
  localparam logic [2:0] SFollow = 3'd4;
  localparam logic [2:0] SWalk   = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [cctm_pkg::AddrW-1:0]  ptr_q, ptr_d;
  logic [cctm_pkg::DataW-1:0]  cl_q, cl_d;
  logic                        first_q, first_d;
  logic [cctm_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [cctm_pkg::CntW-1:0]   cnt_n;

  logic [cctm_pkg::DataW-1:0]  mem_q [cctm_pkg::Entries];
  logic [cctm_pkg::DataW-1:0]  rdata_q;
  logic                        fwd_q, fwd_d;
  logic [cctm_pkg::DataW-1:0]  fwd_data_q;

  logic                        we;
  logic [cctm_pkg::AddrW-1:0]  waddr;
  logic [cctm_pkg::DataW-1:0]  wdata;
  logic [cctm_pkg::AddrW-1:0]  raddr;
  logic [cctm_pkg::DataW-1:0]  rd;
  logic [cctm_pkg::AddrW-1:0]  scan_start;

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q    <= mem_q[raddr];
    fwd_data_q <= wdata;
  end

  // read of an entry written in the same cycle returns the new value
  assign fwd_d = we && (waddr == raddr);
  assign rd    = fwd_q ? fwd_data_q : rdata_q;

  assign scan_start = (alloc_base_i == '0) ? cctm_pkg::AddrW'(1) : alloc_base_i;
  assign cnt_n      = cnt_q + cctm_pkg::CntW'(1);

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    cl_d    = cl_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    we      = 1'b0;
    waddr   = ptr_q;
    wdata   = cctm_pkg::EntryFree;
    raddr   = ptr_q;
    res_o   = '0;

    unique case (state_q)
      SClear: begin
        we    = 1'b1;
        ptr_d = ptr_q + cctm_pkg::AddrW'(1);
        if (ptr_q == '1) begin
          state_d = SIdle;
        end
      end

      SIdle: begin
        if (start_i) begin
          cl_d    = cluster_i;
          first_d = is_first_i;
          cnt_d   = '0;
          unique case (kind_i)
            cctm_pkg::KindAlloc: begin
              if (!is_first_i && !cctm_pkg::valid_cluster(cluster_i)) begin
                res_o.valid  = 1'b1;
                res_o.status = cctm_pkg::StBad;
              end else begin
                raddr   = scan_start;
                ptr_d   = scan_start;
                state_d = SScan;
              end
            end
            cctm_pkg::KindFollow: begin
              if (cctm_pkg::valid_cluster(cluster_i)) begin
                raddr   = cluster_i[cctm_pkg::AddrW-1:0];
                state_d = SFollow;
              end else begin
                res_o.valid  = 1'b1;
                res_o.status = cctm_pkg::StBad;
              end
            end
            cctm_pkg::KindFree: begin
              if (cluster_i == cctm_pkg::EntryEnd) begin
                res_o.valid  = 1'b1;
                res_o.status = cctm_pkg::StOk;
              end else if (cluster_i == cctm_pkg::EntryFree) begin
                res_o.valid  = 1'b1;
                res_o.status = cctm_pkg::StBroken;
              end else if (!cctm_pkg::in_range(cluster_i)) begin
                res_o.valid  = 1'b1;
                res_o.status = cctm_pkg::StBad;
              end else begin
                raddr   = cluster_i[cctm_pkg::AddrW-1:0];
                ptr_d   = cluster_i[cctm_pkg::AddrW-1:0];
                state_d = SWalk;
              end
            end
            cctm_pkg::KindLoad: begin
              res_o.valid = 1'b1;
              if (cctm_pkg::in_range(cluster_i)) begin
                we           = 1'b1;
                waddr        = cluster_i[cctm_pkg::AddrW-1:0];
                wdata        = entry_value_i;
                res_o.status = cctm_pkg::StOk;
              end else begin
                res_o.status = cctm_pkg::StBad;
              end
            end
            default: ;
          endcase
        end
      end

      SScan: begin
        if (rd == cctm_pkg::EntryFree) begin
          we = 1'b1;
          if (first_q) begin
            waddr         = ptr_q;
            wdata         = cctm_pkg::EntryEnd;
            res_o.valid   = 1'b1;
            res_o.status  = cctm_pkg::StOk;
            res_o.cluster = cctm_pkg::DataW'(ptr_q);
            state_d       = SIdle;
          end else begin
            waddr   = cl_q[cctm_pkg::AddrW-1:0];
            wdata   = cctm_pkg::DataW'(ptr_q);
            state_d = SEnd;
          end
        end else if (ptr_q == '1) begin
          res_o.valid  = 1'b1;
          res_o.status = cctm_pkg::StFull;
          state_d      = SIdle;
        end else begin
          ptr_d = ptr_q + cctm_pkg::AddrW'(1);
          raddr = ptr_q + cctm_pkg::AddrW'(1);
        end
      end

      SEnd: begin
        we            = 1'b1;
        waddr         = ptr_q;
        wdata         = cctm_pkg::EntryEnd;
        res_o.valid   = 1'b1;
        res_o.status  = cctm_pkg::StOk;
        res_o.cluster = cctm_pkg::DataW'(ptr_q);
        state_d       = SIdle;
      end

      SFollow: begin
        res_o.valid   = 1'b1;
        res_o.status  = cctm_pkg::StOk;
        res_o.cluster = rd;
        state_d       = SIdle;
      end

      SWalk: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = cctm_pkg::EntryFree;
        cnt_d = cnt_n;
        if (rd == cctm_pkg::EntryEnd) begin
          res_o.valid  = 1'b1;
          res_o.status = cctm_pkg::StOk;
          res_o.count  = cnt_n;
          state_d      = SIdle;
        end else if (rd == cctm_pkg::EntryFree) begin
          res_o.valid  = 1'b1;
          res_o.status = cctm_pkg::StBroken;
          res_o.count  = cnt_n;
          state_d      = SIdle;
        end else if (!cctm_pkg::in_range(rd)) begin
          res_o.valid  = 1'b1;
          res_o.status = cctm_pkg::StBad;
          res_o.count  = cnt_n;
          state_d      = SIdle;
        end else if (cnt_n >= cctm_pkg::CntW'(cctm_pkg::Entries)) begin
          res_o.valid  = 1'b1;
          res_o.status = cctm_pkg::StLoop;
          res_o.count  = cnt_n;
          state_d      = SIdle;
        end else begin
          raddr = rd[cctm_pkg::AddrW-1:0];
          ptr_d = rd[cctm_pkg::AddrW-1:0];
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      ptr_q   <= '0;
      fwd_q   <= 1'b0;
      cnt_q   <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fwd_q   <= fwd_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q <= cl_d;
  end

  assign busy_o = (state_q != SIdle);

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxShown     = 10;
  localparam int unsigned SettleCycles = 4200;
  localparam int unsigned RandItems    = 110;
  localparam int          TrackDut     = 0;
  localparam int          TrackPlan    = 1;

  typedef enum logic [1:0] {EntCmd, EntCfg, EntDrain} entry_kind_e;

  typedef struct {
    entry_kind_e                what;
    logic [cctm_pkg::KindW-1:0] kind;
    logic [cctm_pkg::DataW-1:0] cluster;
    logic                       first;
    logic [cctm_pkg::DataW-1:0] value;
    logic [cctm_pkg::AddrW-1:0] ds;
  } pending_t;

  typedef struct packed {
    logic [cctm_pkg::StatW-1:0] status;
    logic [cctm_pkg::DataW-1:0] cluster;
    logic [cctm_pkg::CntW-1:0]  count;
  } outcome_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cmd_start   = 1'b0;
  logic [cctm_pkg::KindW-1:0] cmd_kind    = cctm_pkg::KindFollow;
  logic [cctm_pkg::DataW-1:0] cmd_cluster = '0;
  logic                       cmd_first   = 1'b0;
  logic [cctm_pkg::DataW-1:0] cmd_value   = '0;
  logic                       ds_we       = 1'b0;
  logic [cctm_pkg::AddrW-1:0] ds_value    = cctm_pkg::AllocBaseRst;
  logic                       busy;
  logic                       done;
  logic [cctm_pkg::StatW-1:0] res_status;
  logic [cctm_pkg::DataW-1:0] res_cluster;
  logic [cctm_pkg::CntW-1:0]  res_count;

  // one table copy follows the dut, the other plans the stimulus ahead of time
  logic [cctm_pkg::DataW-1:0] chain_table [2][cctm_pkg::Entries];
  logic [cctm_pkg::AddrW-1:0] ds_copy [2];

  pending_t    pending_q[$];
  outcome_t    results_due_q[$];
  int unsigned idle_left     = 0;
  int unsigned calm_left     = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;

  cluster_chain_table_manager i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (cmd_start),
    .busy_o         (busy),
    .kind_i         (cmd_kind),
    .cluster_i      (cmd_cluster),
    .is_first_i     (cmd_first),
    .entry_value_i  (cmd_value),
    .alloc_base_we_i(ds_we),
    .alloc_base_i   (ds_value),
    .done_o         (done),
    .status_o       (res_status),
    .cluster_out_o  (res_cluster),
    .freed_count_o  (res_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic is_link(logic [cctm_pkg::DataW-1:0] c);
    return (c != cctm_pkg::EntryFree) && (c != cctm_pkg::EntryEnd) &&
           (c < cctm_pkg::Entries);
  endfunction

  function automatic outcome_t apply_command(input int copy,
      input logic [cctm_pkg::KindW-1:0] kind, input logic [cctm_pkg::DataW-1:0] cl,
      input logic first, input logic [cctm_pkg::DataW-1:0] value);
    outcome_t                   r;
    int unsigned                idx;
    int unsigned                walked;
    logic [cctm_pkg::DataW-1:0] link;
    logic                       stop;
    r = '0;
    case (kind)
      cctm_pkg::KindAlloc: begin
        if (!first && !is_link(cl)) begin
          r.status = cctm_pkg::StBad;
        end else begin
          stop = 1'b0;
          idx = (ds_copy[copy] == 0) ? 1 : 32'(ds_copy[copy]);
          while (idx < cctm_pkg::Entries && !stop) begin
            if (chain_table[copy][idx] == cctm_pkg::EntryFree) stop = 1'b1;
            else idx++;
          end
          if (!stop) begin
            r.status = cctm_pkg::StFull;
          end else begin
            if (!first) chain_table[copy][cl[cctm_pkg::AddrW-1:0]] = idx[cctm_pkg::DataW-1:0];
            chain_table[copy][idx] = cctm_pkg::EntryEnd;
            r.cluster = idx[cctm_pkg::DataW-1:0];
          end
        end
      end
      cctm_pkg::KindFollow: begin
        if (is_link(cl)) r.cluster = chain_table[copy][cl[cctm_pkg::AddrW-1:0]];
        else r.status = cctm_pkg::StBad;
      end
      cctm_pkg::KindFree: begin
        link = cl;
        walked = 0;
        stop = 1'b0;
        while (link != cctm_pkg::EntryEnd && !stop) begin
          if (link == cctm_pkg::EntryFree) begin
            r.status = cctm_pkg::StBroken;
            stop = 1'b1;
          end else if (link >= cctm_pkg::Entries) begin
            r.status = cctm_pkg::StBad;
            stop = 1'b1;
          end else if (walked >= cctm_pkg::Entries) begin
            r.status = cctm_pkg::StLoop;
            stop = 1'b1;
          end else begin
            idx = 32'(link);
            link = chain_table[copy][idx];
            chain_table[copy][idx] = cctm_pkg::EntryFree;
            walked++;
          end
        end
        r.count = walked[cctm_pkg::CntW-1:0];
      end
      default: begin
        if (cl < cctm_pkg::Entries) chain_table[copy][cl[cctm_pkg::AddrW-1:0]] = value;
        else r.status = cctm_pkg::StBad;
      end
    endcase
    return r;
  endfunction

  function automatic outcome_t plan_cmd(input logic [cctm_pkg::KindW-1:0] kind,
      input logic [cctm_pkg::DataW-1:0] cl, input logic first,
      input logic [cctm_pkg::DataW-1:0] value);
    pending_t e;
    e.what = EntCmd;
    e.kind = kind;
    e.cluster = cl;
    e.first = first;
    e.value = value;
    e.ds = '0;
    pending_q.push_back(e);
    return apply_command(TrackPlan, kind, cl, first, value);
  endfunction

  function automatic void plan_pause(input entry_kind_e what,
      input logic [cctm_pkg::AddrW-1:0] ds);
    pending_t e;
    e.what = what;
    e.kind = cctm_pkg::KindFollow;
    e.cluster = '0;
    e.first = 1'b0;
    e.value = '0;
    e.ds = ds;
    pending_q.push_back(e);
    if (what == EntCfg) ds_copy[TrackPlan] = ds;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic [cctm_pkg::DataW-1:0] noise_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return cctm_pkg::DataW'($urandom_range(1, 200));
    if (roll < 55) return cctm_pkg::EntryFree;
    if (roll < 65) return cctm_pkg::EntryEnd;
    if (roll < 80) return cctm_pkg::DataW'($urandom_range(cctm_pkg::Entries - 1));
    return cctm_pkg::DataW'($urandom_range(16'hFFFF));
  endfunction

  always @(posedge clk_i) begin : drive
    logic     nxt_start;
    logic     nxt_we;
    pending_t head;
    if (rst_ni) begin
      nxt_start = cmd_start;
      nxt_we = 1'b0;
      if (cmd_start && !busy) begin
        results_due_q.push_back(apply_command(TrackDut, cmd_kind, cmd_cluster, cmd_first,
                                              cmd_value));
        nxt_start = 1'b0;
        idle_left = pick_gap();
      end
      if (!nxt_start && !ds_we && pending_q.size() > 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_q[0].what == EntCmd) begin
          head = pending_q.pop_front();
          nxt_start = 1'b1;
          cmd_kind <= head.kind;
          cmd_cluster <= head.cluster;
          cmd_first <= head.first;
          cmd_value <= head.value;
        end else if (results_due_q.size() == 0 && !busy) begin
          // block idle: write the alloc base or simply hold off
          head = pending_q.pop_front();
          if (head.what == EntCfg) begin
            nxt_we = 1'b1;
            ds_value <= head.ds;
            ds_copy[TrackDut] = head.ds;
          end
          idle_left = $urandom_range(0, 8);
        end
      end
      cmd_start <= nxt_start;
      ds_we <= nxt_we;
    end
  end

  always @(posedge clk_i) begin : monitor
    outcome_t want;
    if (rst_ni && done) begin
      if (results_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected result: status %0d cluster %h count %0d",
                   res_status, res_cluster, res_count);
      end else begin
        want = results_due_q.pop_front();
        if (res_status !== want.status || res_cluster !== want.cluster ||
            res_count !== want.count) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("result %0d: expected status %0d cluster %h count %0d, got %0d %h %0d",
                     results_seen, want.status, want.cluster, want.count,
                     res_status, res_cluster, res_count);
        end
      end
      results_seen++;
    end
  end

  initial begin
    outcome_t                   got;
    logic [cctm_pkg::DataW-1:0] tail;
    logic [cctm_pkg::DataW-1:0] link;
    logic [cctm_pkg::DataW-1:0] heads_q[$];
    int unsigned                rand_n;
    int unsigned                roll;
    int unsigned                pick;
    int unsigned                steps;
    int unsigned                phase_left;
    logic [cctm_pkg::AddrW-1:0] ds;

    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < cctm_pkg::Entries; i++) chain_table[c][i] = cctm_pkg::EntryFree;
      ds_copy[c] = cctm_pkg::AllocBaseRst;
    end

    // bad clusters on follow and allocate, then a short chain and its walk
    void'(plan_cmd(cctm_pkg::KindFollow, cctm_pkg::EntryFree, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFollow, cctm_pkg::EntryEnd, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFollow, 16'h1000, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFollow, 16'd17, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindAlloc, cctm_pkg::EntryEnd, 1'b1, 16'hFFFF));
    void'(plan_cmd(cctm_pkg::KindAlloc, 16'd17, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindAlloc, cctm_pkg::EntryFree, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindAlloc, cctm_pkg::EntryEnd, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindAlloc, 16'h1000, 1'b0, '0));
    // previous cluster is the free entry the scan finds
    void'(plan_cmd(cctm_pkg::KindAlloc, 16'd19, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFollow, 16'd17, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFollow, 16'd18, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFree, 16'd17, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFree, cctm_pkg::EntryEnd, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFree, cctm_pkg::EntryFree, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFree, 16'hF000, 1'b0, '0));
    // walk that runs into a free entry, and one that leaves the table
    void'(plan_cmd(cctm_pkg::KindLoad, 16'd50, 1'b0, 16'd100));
    void'(plan_cmd(cctm_pkg::KindFree, 16'd50, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindLoad, 16'd60, 1'b0, 16'h2000));
    void'(plan_cmd(cctm_pkg::KindFree, 16'd60, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindLoad, 16'hFFFF, 1'b0, 16'h5A5A));
    void'(plan_cmd(cctm_pkg::KindLoad, 16'd0, 1'b0, 16'hFFFF));
    void'(plan_cmd(cctm_pkg::KindLoad, 16'd4095, 1'b0, 16'hFFFF));
    // table full from the top of the range
    plan_pause(EntCfg, 12'd4095);
    void'(plan_cmd(cctm_pkg::KindAlloc, 16'd5, 1'b1, '0));
    void'(plan_cmd(cctm_pkg::KindAlloc, 16'd4095, 1'b0, '0));
    // entry zero is never handed out
    plan_pause(EntCfg, 12'd0);
    void'(plan_cmd(cctm_pkg::KindLoad, 16'd0, 1'b0, cctm_pkg::EntryFree));
    void'(plan_cmd(cctm_pkg::KindAlloc, 16'd0, 1'b1, '0));
    void'(plan_cmd(cctm_pkg::KindFree, 16'd4095, 1'b0, '0));
    void'(plan_cmd(cctm_pkg::KindFree, 16'd19, 1'b0, '0));

    rand_n = 0;
    phase_left = 0;
    while (rand_n < RandItems) begin
      if (phase_left == 0) begin
        case ($urandom_range(3))
          0: ds = cctm_pkg::AddrW'($urandom_range(1, 40));
          1: ds = '0;
          2: ds = cctm_pkg::AddrW'($urandom_range(17, 300));
          default: ds = cctm_pkg::AddrW'($urandom_range(3000, 4095));
        endcase
        plan_pause(EntCfg, ds);
        phase_left = $urandom_range(25, 45);
      end
      if (rand_n >= RandItems / 2 && rand_n < RandItems / 2 + 8) plan_pause(EntDrain, '0);
      roll = $urandom_range(99);
      steps = 0;
      if (roll < 45) begin
        got = plan_cmd(cctm_pkg::KindAlloc, cctm_pkg::DataW'($urandom_range(16'hFFFF)), 1'b1,
                       cctm_pkg::DataW'($urandom_range(16'hFFFF)));
        steps++;
        if (got.status == cctm_pkg::StOk) begin
          heads_q.push_back(got.cluster);
          tail = got.cluster;
          repeat ($urandom_range(1, 8)) begin
            got = plan_cmd(cctm_pkg::KindAlloc, tail, 1'b0,
                           cctm_pkg::DataW'($urandom_range(16'hFFFF)));
            steps++;
            if (got.status == cctm_pkg::StOk) tail = got.cluster;
          end
        end
      end else if (roll < 60 && heads_q.size() > 0) begin
        link = heads_q[$urandom_range(heads_q.size() - 1)];
        while (is_link(link) && steps < 10) begin
          got = plan_cmd(cctm_pkg::KindFollow, link, 1'($urandom_range(1)),
                         cctm_pkg::DataW'($urandom_range(16'hFFFF)));
          link = got.cluster;
          steps++;
        end
        if (steps == 0) begin
          void'(plan_cmd(cctm_pkg::KindFollow, link, 1'b0, '0));
          steps++;
        end
      end else if (roll < 75 && heads_q.size() > 0) begin
        pick = $urandom_range(heads_q.size() - 1);
        link = heads_q[pick];
        heads_q.delete(pick);
        void'(plan_cmd(cctm_pkg::KindFree, link, 1'($urandom_range(1)),
                       cctm_pkg::DataW'($urandom_range(16'hFFFF))));
        steps++;
      end else begin
        void'(plan_cmd(cctm_pkg::KindW'($urandom_range(3)), noise_word(),
                       1'($urandom_range(1)), noise_word()));
        steps++;
      end
      rand_n += steps;
      phase_left = (phase_left > steps) ? phase_left - steps : 0;
    end

    while (pending_q.size() > 0 || cmd_start) @(posedge clk_i);
    while (results_due_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && results_due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
